/* rtl/lsr_pkg.sv */
package lsr_pkg;

    localparam int COORD_BITS = 11;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DELTA_BITS;
    localparam int NUM_BITS   = 2 * COORD_BITS + 3;
    localparam int CNT_BITS   = $clog2(COORD_BITS);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DELTA_BITS-1:0] delta_t;
    typedef logic signed [NUM_BITS-1:0]   num_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [1:0] MODE_VERT = 2'd0;
    localparam logic [1:0] MODE_HORZ = 2'd1;
    localparam logic [1:0] MODE_XMAJ = 2'd2;
    localparam logic [1:0] MODE_YMAJ = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/lsr_if.sv */
interface lsr_in_if;
    import lsr_pkg::*;

    logic   valid;
    logic   ready;
    logic   opcode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;

    modport source (output valid, opcode, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, opcode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsr_out_if;
    import lsr_pkg::*;

    logic   valid;
    logic   ready;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   vertical_mark;
    logic   last_pixel;

    modport source (output valid, pixel_x, pixel_y, vertical_mark, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, vertical_mark, last_pixel, output ready);
endinterface

/* rtl/lsr_divider.sv */
module lsr_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lsr_pkg::num_t      dividend,
    input  lsr_pkg::delta_t    divisor,
    output lsr_pkg::coord_t    quotient,
    output lsr_pkg::div_stat_t stat
);
    import lsr_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  neg_reg;
    logic [COORD_BITS-1:0] dmag_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [COORD_BITS-1:0] low_reg;
    logic [COORD_BITS-1:0] q_reg;

    logic [NUM_BITS-1:0]   num_abs;
    logic [DELTA_BITS-1:0] div_abs;
    logic [COORD_BITS+1:0] trial;
    logic                  fits;

    assign num_abs = dividend[NUM_BITS-1] ? NUM_BITS'(-dividend) : NUM_BITS'(dividend);
    assign div_abs = divisor[DELTA_BITS-1] ? DELTA_BITS'(-divisor) : DELTA_BITS'(divisor);

    // The quotient is known to fit in COORD_BITS bits, so the partial remainder
    // starts from the dividend's upper bits and stays below the divisor.
    assign trial = {1'b0, rem_reg, low_reg[COORD_BITS-1]} - {2'b00, dmag_reg};
    assign fits  = ~trial[COORD_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == CNT_BITS'(COORD_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= dividend[NUM_BITS-1] ^ divisor[DELTA_BITS-1];
            dmag_reg <= div_abs[COORD_BITS-1:0];
            rem_reg  <= num_abs[COORD_BITS +: COORD_BITS];
            low_reg  <= num_abs[COORD_BITS-1:0];
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= trial[COORD_BITS-1:0];
            else
                rem_reg <= {rem_reg[COORD_BITS-2:0], low_reg[COORD_BITS-1]};
            low_reg <= {low_reg[COORD_BITS-2:0], 1'b0};
            q_reg   <= {q_reg[COORD_BITS-2:0], fits};
        end
    end

    assign quotient  = neg_reg ? coord_t'(-q_reg) : coord_t'(q_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

/* rtl/line_segment_rasterizer_top.sv */
// Load word: produces no pixel, and the block is ready again next cycle.
// Step word, axis-aligned segment: pixel goes via ST_EMIT into the output register.
// Step word, sloped segment: ST_MUL1 and ST_MUL2 on the shared multiplier (two products),
// then ST_DSTART, ST_DWAIT on the restoring divider (one quotient bit per cycle), ST_EMIT.
// One word is in flight at a time; a waiting pixel holds the next one back only at the end.
// Asynchronous active-low reset clears the segment, the walk and both handshakes.
module line_segment_rasterizer_top (
    input  logic             clk,
    input  logic             rst_n,
    lsr_in_if.sink           item_in,
    lsr_out_if.source        pix_out
);
    import lsr_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL1   = 3'd1;
    localparam logic [2:0] ST_MUL2   = 3'd2;
    localparam logic [2:0] ST_DSTART = 3'd3;
    localparam logic [2:0] ST_DWAIT  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0] state_reg, state_next;
    coord_t     x0_reg, x0_next;
    coord_t     y0_reg, y0_next;
    delta_t     dx_reg, dx_next;
    delta_t     dy_reg, dy_next;
    coord_t     cursor_reg, cursor_next;
    coord_t     stop_reg, stop_next;
    logic [1:0] mode_reg, mode_next;
    logic       active_reg, active_next;
    logic       out_valid_reg, out_valid_next;

    coord_t     px_reg, px_next;
    coord_t     py_reg, py_next;
    num_t       acc_reg, acc_next;
    coord_t     out_px_reg, out_px_next;
    coord_t     out_py_reg, out_py_next;
    logic       out_vert_reg, out_vert_next;
    logic       out_last_reg, out_last_next;

    logic       in_fire;
    delta_t     in_dx, in_dy;
    logic [DELTA_BITS-1:0] in_adx, in_ady;
    logic [1:0] in_mode;
    coord_t     in_lo, in_hi;

    logic       xmaj;
    delta_t     start_minor, d_major, d_minor, offset;
    delta_t     mul_a, mul_b;
    logic signed [PROD_BITS-1:0] prod;
    num_t       prod_ext;
    delta_t     cursor_inc;
    logic       is_last;

    coord_t     quotient;
    div_stat_t  div_stat;

    assign item_in.ready = (state_reg == ST_IDLE);
    assign in_fire       = item_in.valid & item_in.ready;

    // Segment setup from the load word.
    assign in_dx  = {item_in.end_x[COORD_BITS-1], item_in.end_x}
                  - {item_in.start_x[COORD_BITS-1], item_in.start_x};
    assign in_dy  = {item_in.end_y[COORD_BITS-1], item_in.end_y}
                  - {item_in.start_y[COORD_BITS-1], item_in.start_y};
    assign in_adx = in_dx[DELTA_BITS-1] ? DELTA_BITS'(-in_dx) : DELTA_BITS'(in_dx);
    assign in_ady = in_dy[DELTA_BITS-1] ? DELTA_BITS'(-in_dy) : DELTA_BITS'(in_dy);

    always_comb
    begin
        if (in_dx == '0)
            in_mode = MODE_VERT;
        else if (in_dy == '0)
            in_mode = MODE_HORZ;
        else if (in_adx > in_ady)
            in_mode = MODE_XMAJ;
        else
            in_mode = MODE_YMAJ;

        if (in_mode == MODE_HORZ || in_mode == MODE_XMAJ)
        begin
            in_lo = (item_in.start_x < item_in.end_x) ? item_in.start_x : item_in.end_x;
            in_hi = (item_in.start_x < item_in.end_x) ? item_in.end_x : item_in.start_x;
        end
        else
        begin
            in_lo = (item_in.start_y < item_in.end_y) ? item_in.start_y : item_in.end_y;
            in_hi = (item_in.start_y < item_in.end_y) ? item_in.end_y : item_in.start_y;
        end
    end

    // Sloped walk: minor = (start_minor * d_major + d_minor * offset) / d_major.
    assign xmaj        = (mode_reg == MODE_XMAJ);
    assign start_minor = xmaj ? {y0_reg[COORD_BITS-1], y0_reg} : {x0_reg[COORD_BITS-1], x0_reg};
    assign d_major     = xmaj ? dx_reg : dy_reg;
    assign d_minor     = xmaj ? dy_reg : dx_reg;
    assign offset      = {cursor_reg[COORD_BITS-1], cursor_reg}
                       - (xmaj ? {x0_reg[COORD_BITS-1], x0_reg} : {y0_reg[COORD_BITS-1], y0_reg});

    // One multiplier serves both products on consecutive cycles.
    assign mul_a    = (state_reg == ST_MUL1) ? start_minor : d_minor;
    assign mul_b    = (state_reg == ST_MUL1) ? d_major : offset;
    assign prod     = mul_a * mul_b;
    assign prod_ext = {{(NUM_BITS - PROD_BITS){prod[PROD_BITS-1]}}, prod};

    assign cursor_inc = {cursor_reg[COORD_BITS-1], cursor_reg} + DELTA_BITS'(1);
    assign is_last    = (cursor_inc >= $signed({stop_reg[COORD_BITS-1], stop_reg}));

    lsr_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DSTART),
        .dividend (acc_reg),
        .divisor  (d_major),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        cursor_next    = cursor_reg;
        stop_next      = stop_reg;
        mode_next      = mode_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        acc_next       = acc_reg;
        out_px_next    = out_px_reg;
        out_py_next    = out_py_reg;
        out_vert_next  = out_vert_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && pix_out.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (item_in.opcode == OP_LOAD)
                    begin
                        x0_next     = item_in.start_x;
                        y0_next     = item_in.start_y;
                        dx_next     = in_dx;
                        dy_next     = in_dy;
                        mode_next   = in_mode;
                        cursor_next = in_lo;
                        stop_next   = in_hi;
                        active_next = (in_lo < in_hi);
                    end
                    else if (active_reg)
                    begin
                        case (mode_reg)
                            MODE_VERT:
                            begin
                                px_next    = x0_reg;
                                py_next    = cursor_reg;
                                state_next = ST_EMIT;
                            end
                            MODE_HORZ:
                            begin
                                px_next    = cursor_reg;
                                py_next    = y0_reg;
                                state_next = ST_EMIT;
                            end
                            default:
                            begin
                                state_next = ST_MUL1;
                            end
                        endcase
                    end
                end
            end
            ST_MUL1:
            begin
                acc_next   = prod_ext;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                acc_next   = acc_reg + prod_ext;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_stat.done)
                begin
                    if (xmaj)
                    begin
                        px_next = cursor_reg;
                        py_next = quotient;
                    end
                    else
                    begin
                        px_next = quotient;
                        py_next = cursor_reg;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || pix_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_px_next    = px_reg;
                    out_py_next    = py_reg;
                    out_vert_next  = (mode_reg == MODE_VERT);
                    out_last_next  = is_last;
                    cursor_next    = cursor_inc[COORD_BITS-1:0];
                    active_next    = ~is_last;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x0_reg        <= '0;
            y0_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            cursor_reg    <= '0;
            stop_reg      <= '0;
            mode_reg      <= MODE_VERT;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x0_reg        <= x0_next;
            y0_reg        <= y0_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            cursor_reg    <= cursor_next;
            stop_reg      <= stop_next;
            mode_reg      <= mode_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        acc_reg      <= acc_next;
        out_px_reg   <= out_px_next;
        out_py_reg   <= out_py_next;
        out_vert_reg <= out_vert_next;
        out_last_reg <= out_last_next;
    end

    assign pix_out.valid         = out_valid_reg;
    assign pix_out.pixel_x       = out_px_reg;
    assign pix_out.pixel_y       = out_py_reg;
    assign pix_out.vertical_mark = out_vert_reg;
    assign pix_out.last_pixel    = out_last_reg;

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DWAIT)
        else $error("divider finished outside of the wait state");

    a_div_busy_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == ST_DWAIT)
        else $error("divider running outside of the wait state");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> cursor_reg < stop_reg)
        else $error("active walk has its cursor at or past the stop");

    a_pixel_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("output word appeared without an emit step");

endmodule
